// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions clocked on clk and disabled
// while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define OTAC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// Implication checked at every rising edge outside reset.
`define OTAC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

`endif

// ===== rtl/otac_pkg.sv =====
// ----------------------------------------------------------------------------
// otac_pkg
// Shared types, constants and the box overlap test of the object table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package otac_pkg;

	localparam int MAX_OBJECTS_DEF = 32;

	localparam int ROW_W = 6;   // table index width at the largest table size
	localparam int CNT_W = 7;   // entry count, holds the table size itself
	localparam int ID_W = 16;
	localparam int KIND_W = 4;
	localparam int KEY_W = ID_W + KIND_W;
	localparam int BOX_W = 48;
	localparam int STAT_W = 3;

	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [STAT_W-1:0] ST_UPDATED = 3'd0;
	localparam logic [STAT_W-1:0] ST_ADDED = 3'd1;
	localparam logic [STAT_W-1:0] ST_REMOVED = 3'd2;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
	localparam logic [STAT_W-1:0] ST_FULL = 3'd4;
	localparam logic [STAT_W-1:0] ST_QUERY = 3'd5;

	typedef struct packed {
		logic              we;
		logic [ROW_W-1:0]  waddr;
		logic [KEY_W-1:0]  wkey;
		logic [BOX_W-1:0]  wbox;
		logic              re;
		logic [ROW_W-1:0]  raddr;
	} mem_req_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [BOX_W-1:0]  box;
	} mem_rsp_t;

	// Inclusive overlap of two boxes. Box layout: x[47:32], y[31:16],
	// width[15:8], height[7:0]. Edges are worked out in 18 bits so that
	// right and bottom never wrap.
	function automatic logic box_overlap(input logic [BOX_W-1:0] a,
	                                     input logic [BOX_W-1:0] b);
		logic signed [17:0] ax;
		logic signed [17:0] ay;
		logic signed [17:0] bx;
		logic signed [17:0] by;
		logic signed [17:0] ar;
		logic signed [17:0] ab;
		logic signed [17:0] br;
		logic signed [17:0] bb;
		ax = {{2{a[47]}}, a[47:32]};
		ay = {{2{a[31]}}, a[31:16]};
		bx = {{2{b[47]}}, b[47:32]};
		by = {{2{b[31]}}, b[31:16]};
		ar = ax + $signed({10'b0, a[15:8]}) - 18'sd1;
		ab = ay + $signed({10'b0, a[7:0]}) - 18'sd1;
		br = bx + $signed({10'b0, b[15:8]}) - 18'sd1;
		bb = by + $signed({10'b0, b[7:0]}) - 18'sd1;
		return !((ax > br) || (bx > ar) || (ay > bb) || (by > ab));
	endfunction

endpackage

// ===== rtl/otac_mem.sv =====
// ----------------------------------------------------------------------------
// otac_mem
// Key and box storage of the object table: one write port and one read
// port, read data registered and held while no read is issued.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module otac_mem
	import otac_pkg::*;
#(
	parameter int MAX_OBJECTS = MAX_OBJECTS_DEF
) (
	input  logic     clk,
	input  mem_req_t req,
	output mem_rsp_t rsp
);

	localparam int IDX_W = $clog2(MAX_OBJECTS);

	logic [KEY_W-1:0] key_mem [MAX_OBJECTS];
	logic [BOX_W-1:0] box_mem [MAX_OBJECTS];

	// The controller never reads and writes one entry in the same cycle,
	// so no bypass is needed.
	always_ff @(posedge clk) begin
		if (req.we) begin
			key_mem[req.waddr[IDX_W-1:0]] <= req.wkey;
			box_mem[req.waddr[IDX_W-1:0]] <= req.wbox;
		end
		if (req.re) begin
			rsp.key <= key_mem[req.raddr[IDX_W-1:0]];
			rsp.box <= box_mem[req.raddr[IDX_W-1:0]];
		end
	end

endmodule

// ===== rtl/otac_ctrl.sv =====
// ----------------------------------------------------------------------------
// otac_ctrl
// Command sequencer: key search, insert, update, remove with shift-down,
// row collision scan and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module otac_ctrl
	import otac_pkg::*;
#(
	parameter int MAX_OBJECTS = MAX_OBJECTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              command,
	input  logic [ID_W-1:0]   object_id,
	input  logic [KIND_W-1:0] object_kind,
	input  logic [15:0]       pos_x,
	input  logic [15:0]       pos_y,
	input  logic [7:0]        box_width,
	input  logic [7:0]        box_height,
	input  logic              alive,
	input  logic [ROW_W-1:0]  row_index,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [STAT_W-1:0] status,
	output logic              hit,
	output logic [ROW_W-1:0]  partner_index,
	output logic [ID_W-1:0]   partner_id,
	output logic [KIND_W-1:0] partner_kind,
	output logic [CNT_W-1:0]  entry_total,
	output logic              last,
	output mem_req_t          mem_req,
	input  mem_rsp_t          mem_rsp
);

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_OBJECTS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SRCH,
		S_ACT,
		S_SHIFT,
		S_QROW,
		S_QLOAD,
		S_QSCAN,
		S_RESP
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  addr_q;
	logic [KEY_W-1:0]  key_q;
	logic [BOX_W-1:0]  box_q;
	logic              alive_q;
	logic [ROW_W-1:0]  row_q;
	logic              found_q;
	logic [ROW_W-1:0]  found_idx_q;
	logic [STAT_W-1:0] status_q;
	logic [BOX_W-1:0]  rbox_q;
	logic              pend_v_q;
	logic [ROW_W-1:0]  pend_idx_q;
	logic [KEY_W-1:0]  pend_key_q;
	logic              rd_v_s1;
	logic [ROW_W-1:0]  rd_idx_s1;

	logic              out_valid_q;
	logic [STAT_W-1:0] out_status_q;
	logic              out_hit_q;
	logic [ROW_W-1:0]  out_idx_q;
	logic [KEY_W-1:0]  out_key_q;
	logic [CNT_W-1:0]  out_total_q;
	logic              out_last_q;

	logic accept;
	logic more;
	logic key_hit;
	logic ovl_hit;
	logic out_blocked;
	logic scan_done;
	logic freeze;

	assign in_stall    = (state_q != S_IDLE);
	assign accept      = in_valid && !in_stall;
	assign more        = (addr_q < cnt_q);
	assign key_hit     = rd_v_s1 && (mem_rsp.key == key_q);
	assign ovl_hit     = rd_v_s1 && box_overlap(rbox_q, mem_rsp.box);
	assign out_blocked = out_valid_q && out_stall;
	assign scan_done   = !more && !rd_v_s1;
	// A second hit must push the held one out; if the result register is
	// full and stalled the whole scan waits, memory read data included.
	assign freeze      = (state_q == S_QSCAN) && ovl_hit && pend_v_q && out_blocked;

	always_comb begin
		mem_req = '0;
		case (state_q)
			S_SRCH: begin
				mem_req.re    = more && !key_hit;
				mem_req.raddr = addr_q[ROW_W-1:0];
			end
			S_ACT: begin
				if (alive_q && (found_q || (cnt_q < MAX_CNT))) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = found_q ? found_idx_q : cnt_q[ROW_W-1:0];
					mem_req.wkey  = key_q;
					mem_req.wbox  = box_q;
				end
			end
			S_SHIFT: begin
				mem_req.re    = more;
				mem_req.raddr = addr_q[ROW_W-1:0];
				if (rd_v_s1) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = rd_idx_s1 - ROW_W'(1);
					mem_req.wkey  = mem_rsp.key;
					mem_req.wbox  = mem_rsp.box;
				end
			end
			S_QROW: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = row_q;
			end
			S_QSCAN: begin
				mem_req.re    = more && !freeze;
				mem_req.raddr = addr_q[ROW_W-1:0];
			end
			default: begin
				mem_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rd_v_s1     <= 1'b0;
			pend_v_q    <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						key_q    <= {object_id, object_kind};
						box_q    <= {pos_x, pos_y, box_width, box_height};
						alive_q  <= alive;
						row_q    <= row_index;
						addr_q   <= '0;
						rd_v_s1  <= 1'b0;
						found_q  <= 1'b0;
						pend_v_q <= 1'b0;
						if (command == CMD_UPDATE) begin
							state_q <= S_SRCH;
						end else if ({1'b0, row_index} < cnt_q) begin
							state_q <= S_QROW;
						end else begin
							status_q <= ST_QUERY;
							state_q  <= S_RESP;
						end
					end
				end
				S_SRCH: begin
					if (key_hit) begin
						found_q     <= 1'b1;
						found_idx_q <= rd_idx_s1;
						rd_v_s1     <= 1'b0;
						state_q     <= S_ACT;
					end else if (scan_done) begin
						state_q <= S_ACT;
					end else begin
						rd_v_s1   <= more;
						rd_idx_s1 <= addr_q[ROW_W-1:0];
						if (more) begin
							addr_q <= addr_q + CNT_W'(1);
						end
					end
				end
				S_ACT: begin
					if (alive_q) begin
						if (found_q) begin
							status_q <= ST_UPDATED;
						end else if (cnt_q < MAX_CNT) begin
							cnt_q    <= cnt_q + CNT_W'(1);
							status_q <= ST_ADDED;
						end else begin
							status_q <= ST_FULL;
						end
						state_q <= S_RESP;
					end else if (found_q) begin
						status_q <= ST_REMOVED;
						addr_q   <= {1'b0, found_idx_q} + CNT_W'(1);
						rd_v_s1  <= 1'b0;
						state_q  <= S_SHIFT;
					end else begin
						status_q <= ST_NOTFOUND;
						state_q  <= S_RESP;
					end
				end
				S_SHIFT: begin
					if (scan_done) begin
						cnt_q   <= cnt_q - CNT_W'(1);
						state_q <= S_RESP;
					end else begin
						rd_v_s1   <= more;
						rd_idx_s1 <= addr_q[ROW_W-1:0];
						if (more) begin
							addr_q <= addr_q + CNT_W'(1);
						end
					end
				end
				S_QROW: begin
					state_q <= S_QLOAD;
				end
				S_QLOAD: begin
					rbox_q  <= mem_rsp.box;
					addr_q  <= {1'b0, row_q} + CNT_W'(1);
					rd_v_s1 <= 1'b0;
					state_q <= S_QSCAN;
				end
				S_QSCAN: begin
					if (scan_done) begin
						if (!pend_v_q) begin
							status_q <= ST_QUERY;
							state_q  <= S_RESP;
						end else if (!out_blocked) begin
							out_valid_q  <= 1'b1;
							out_status_q <= ST_QUERY;
							out_hit_q    <= 1'b1;
							out_idx_q    <= pend_idx_q;
							out_key_q    <= pend_key_q;
							out_total_q  <= cnt_q;
							out_last_q   <= 1'b1;
							state_q      <= S_IDLE;
						end
					end else if (!freeze) begin
						if (ovl_hit) begin
							if (pend_v_q) begin
								out_valid_q  <= 1'b1;
								out_status_q <= ST_QUERY;
								out_hit_q    <= 1'b1;
								out_idx_q    <= pend_idx_q;
								out_key_q    <= pend_key_q;
								out_total_q  <= cnt_q;
								out_last_q   <= 1'b0;
							end
							pend_v_q   <= 1'b1;
							pend_idx_q <= rd_idx_s1;
							pend_key_q <= mem_rsp.key;
						end
						rd_v_s1   <= more;
						rd_idx_s1 <= addr_q[ROW_W-1:0];
						if (more) begin
							addr_q <= addr_q + CNT_W'(1);
						end
					end
				end
				S_RESP: begin
					if (!out_blocked) begin
						out_valid_q  <= 1'b1;
						out_status_q <= status_q;
						out_hit_q    <= 1'b0;
						out_idx_q    <= '0;
						out_key_q    <= '0;
						out_total_q  <= cnt_q;
						out_last_q   <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign hit           = out_hit_q;
	assign partner_index = out_idx_q;
	assign partner_id    = out_key_q[KEY_W-1:KIND_W];
	assign partner_kind  = out_key_q[KIND_W-1:0];
	assign entry_total   = out_total_q;
	assign last          = out_last_q;

	`OTAC_ASSERT(a_cnt_bound, cnt_q <= MAX_CNT, "entry count beyond table size")
	`OTAC_ASSERT_IMP(a_mid_is_hit, out_valid_q && !out_last_q, out_status_q == ST_QUERY && out_hit_q, "non-final result is not a query hit")
	`OTAC_ASSERT_IMP(a_rw_apart, mem_req.we && mem_req.re, mem_req.waddr != mem_req.raddr, "read and write hit one entry")
	`OTAC_ASSERT_IMP(a_cnt_change, cnt_q != $past(cnt_q), $past(state_q) == S_ACT || $past(state_q) == S_SHIFT, "entry count changed outside insert or remove")

endmodule

// ===== rtl/object_table_aabb_collision.sv =====
// ----------------------------------------------------------------------------
// object_table_aabb_collision
// A compact table of up to MAX_OBJECTS boxes keyed by id and kind. An
// update transaction inserts, replaces or removes one box (a removal shifts
// the later entries down) and returns one status result. A query
// transaction tests one table row against every later entry and returns
// each overlapping partner, the final one marked last, or a single no-hit
// result. One transaction is handled at a time; the input stalls until its
// last result sits in the output register. All work runs through the
// single read port of the table memory, one entry per cycle, except while a
// query waits on a stalled output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module object_table_aabb_collision
	import otac_pkg::*;
#(
	parameter int MAX_OBJECTS = MAX_OBJECTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              command,
	input  logic [ID_W-1:0]   object_id,
	input  logic [KIND_W-1:0] object_kind,
	input  logic [15:0]       pos_x,
	input  logic [15:0]       pos_y,
	input  logic [7:0]        box_width,
	input  logic [7:0]        box_height,
	input  logic              alive,
	input  logic [ROW_W-1:0]  row_index,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [STAT_W-1:0] status,
	output logic              hit,
	output logic [ROW_W-1:0]  partner_index,
	output logic [ID_W-1:0]   partner_id,
	output logic [KIND_W-1:0] partner_kind,
	output logic [CNT_W-1:0]  entry_total,
	output logic              last
);

	mem_req_t mem_req;
	mem_rsp_t mem_rsp;

	otac_mem #(
		.MAX_OBJECTS(MAX_OBJECTS)
	) u_mem (
		.clk(clk),
		.req(mem_req),
		.rsp(mem_rsp)
	);

	otac_ctrl #(
		.MAX_OBJECTS(MAX_OBJECTS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.object_id    (object_id),
		.object_kind  (object_kind),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.box_width    (box_width),
		.box_height   (box_height),
		.alive        (alive),
		.row_index    (row_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.hit          (hit),
		.partner_index(partner_index),
		.partner_id   (partner_id),
		.partner_kind (partner_kind),
		.entry_total  (entry_total),
		.last         (last),
		.mem_req      (mem_req),
		.mem_rsp      (mem_rsp)
	);

endmodule

// ===== sim/otac_collision_checker.sv =====
// ----------------------------------------------------------------------------
// otac_collision_checker
// Watches both channels of the object table. It keeps its own copy of the
// box table, works out the results of every accepted input transaction and
// compares each accepted output transaction against the oldest one waiting.
// The mismatch count and the number of results still owed go to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module otac_collision_checker
	import otac_pkg::*;
#(
	parameter int MAX_OBJECTS = MAX_OBJECTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic              command,
	input  logic [ID_W-1:0]   object_id,
	input  logic [KIND_W-1:0] object_kind,
	input  logic [15:0]       pos_x,
	input  logic [15:0]       pos_y,
	input  logic [7:0]        box_width,
	input  logic [7:0]        box_height,
	input  logic              alive,
	input  logic [ROW_W-1:0]  row_index,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [STAT_W-1:0] status,
	input  logic              hit,
	input  logic [ROW_W-1:0]  partner_index,
	input  logic [ID_W-1:0]   partner_id,
	input  logic [KIND_W-1:0] partner_kind,
	input  logic [CNT_W-1:0]  entry_total,
	input  logic              last,
	output int                fail_count,
	output int                pending
);

	typedef struct {
		logic [STAT_W-1:0] status;
		logic              hit;
		logic [ROW_W-1:0]  partner_index;
		logic [ID_W-1:0]   partner_id;
		logic [KIND_W-1:0] partner_kind;
		logic [CNT_W-1:0]  entry_total;
		logic              last;
	} table_result_t;

	logic [KEY_W-1:0] slot_key [MAX_OBJECTS];
	int               slot_x   [MAX_OBJECTS];
	int               slot_y   [MAX_OBJECTS];
	int               slot_w   [MAX_OBJECTS];
	int               slot_h   [MAX_OBJECTS];
	int               occupancy;
	int               mismatches;
	table_result_t    owed_results [$];

	table_result_t    res;
	table_result_t    held;
	table_result_t    want;
	bit               have_held;
	logic [KEY_W-1:0] lookup_key;
	logic [STAT_W-1:0] code;
	int               found;
	int               k;

	// Edges are inclusive, so a box of zero extent ends one unit before it starts.
	function automatic bit boxes_overlap(int a, int b);
		return !(slot_x[a] > slot_x[b] + slot_w[b] - 1 ||
		         slot_x[b] > slot_x[a] + slot_w[a] - 1 ||
		         slot_y[a] > slot_y[b] + slot_h[b] - 1 ||
		         slot_y[b] > slot_y[a] + slot_h[a] - 1);
	endfunction

	task automatic store_box(int idx);
		slot_x[idx] = int'($signed(pos_x));
		slot_y[idx] = int'($signed(pos_y));
		slot_w[idx] = int'(box_width);
		slot_h[idx] = int'(box_height);
	endtask

	task automatic check_field(string name, int expected_val, int actual_val);
		if (expected_val != actual_val) begin
			$error("%s expected %0d actual %0d", name, expected_val, actual_val);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occupancy = 0;
			mismatches = 0;
			owed_results.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			// The new transaction is queued first so that a result of the
			// previous one accepted on this edge still finds its own entry.
			if (in_valid && !in_stall) begin
				res = '{default: '0};
				if (command == CMD_QUERY) begin
					have_held = 0;
					if (int'(row_index) < occupancy) begin
						for (k = int'(row_index) + 1; k < occupancy; k++) begin
							if (boxes_overlap(int'(row_index), k)) begin
								if (have_held)
									owed_results.push_back(held);
								held = '{default: '0};
								held.status = ST_QUERY;
								held.hit = 1'b1;
								held.partner_index = ROW_W'(k);
								held.partner_id = slot_key[k][KEY_W-1:KIND_W];
								held.partner_kind = slot_key[k][KIND_W-1:0];
								held.entry_total = CNT_W'(occupancy);
								have_held = 1;
							end
						end
					end
					if (have_held) begin
						held.last = 1'b1;
						owed_results.push_back(held);
					end else begin
						res.status = ST_QUERY;
						res.entry_total = CNT_W'(occupancy);
						res.last = 1'b1;
						owed_results.push_back(res);
					end
				end else begin
					lookup_key = {object_id, object_kind};
					found = -1;
					for (k = 0; k < occupancy; k++)
						if (found < 0 && slot_key[k] == lookup_key)
							found = k;
					if (alive) begin
						if (found >= 0) begin
							store_box(found);
							code = ST_UPDATED;
						end else if (occupancy < MAX_OBJECTS) begin
							slot_key[occupancy] = lookup_key;
							store_box(occupancy);
							occupancy++;
							code = ST_ADDED;
						end else begin
							code = ST_FULL;
						end
					end else if (found >= 0) begin
						for (k = found; k + 1 < occupancy; k++) begin
							slot_key[k] = slot_key[k + 1];
							slot_x[k] = slot_x[k + 1];
							slot_y[k] = slot_y[k + 1];
							slot_w[k] = slot_w[k + 1];
							slot_h[k] = slot_h[k + 1];
						end
						occupancy--;
						code = ST_REMOVED;
					end else begin
						code = ST_NOTFOUND;
					end
					res.status = code;
					res.entry_total = CNT_W'(occupancy);
					res.last = 1'b1;
					owed_results.push_back(res);
				end
			end

			if (out_valid && !out_stall) begin
				if (owed_results.size() == 0) begin
					$error("result with nothing outstanding: status %0d entry_total %0d",
					       status, entry_total);
					mismatches++;
				end else begin
					want = owed_results.pop_front();
					check_field("status", want.status, status);
					check_field("hit", want.hit, hit);
					check_field("partner_index", want.partner_index, partner_index);
					check_field("partner_id", want.partner_id, partner_id);
					check_field("partner_kind", want.partner_kind, partner_kind);
					check_field("entry_total", want.entry_total, entry_total);
					check_field("last", want.last, last);
				end
			end

			fail_count <= mismatches;
			pending <= owed_results.size();
		end
	end

endmodule

// ===== sim/tb_object_table_aabb_collision.sv =====
// ----------------------------------------------------------------------------
// tb_object_table_aabb_collision
// Drives the object table with a short directed sequence over corner
// boxes, edge contact, zero-size boxes, removal with shift and queries out
// of range, then with random upserts, removals and row queries over a
// small key pool so that the table fills, overflows and drains. Both
// channels idle at random. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_object_table_aabb_collision;
	import otac_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 2 * MAX_OBJECTS_DEF + 40;
	localparam int RANDOM_TXNS = 450;
	localparam int KEY_POOL = 40;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              command = CMD_UPDATE;
	logic [ID_W-1:0]   object_id = '0;
	logic [KIND_W-1:0] object_kind = '0;
	logic [15:0]       pos_x = '0;
	logic [15:0]       pos_y = '0;
	logic [7:0]        box_width = '0;
	logic [7:0]        box_height = '0;
	logic              alive = 1'b0;
	logic [ROW_W-1:0]  row_index = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [STAT_W-1:0] status;
	logic              hit;
	logic [ROW_W-1:0]  partner_index;
	logic [ID_W-1:0]   partner_id;
	logic [KIND_W-1:0] partner_kind;
	logic [CNT_W-1:0]  entry_total;
	logic              last;

	int               fail_count;
	int               pending;
	int               tx_idle_pct = 36;
	int               rx_idle_pct = 50;
	int               quiet_cycles = 0;
	logic [KEY_W-1:0] key_pool [KEY_POOL];

	object_table_aabb_collision dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .object_id(object_id), .object_kind(object_kind),
		.pos_x(pos_x), .pos_y(pos_y), .box_width(box_width), .box_height(box_height),
		.alive(alive), .row_index(row_index),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .hit(hit), .partner_index(partner_index),
		.partner_id(partner_id), .partner_kind(partner_kind),
		.entry_total(entry_total), .last(last)
	);

	otac_collision_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .object_id(object_id), .object_kind(object_kind),
		.pos_x(pos_x), .pos_y(pos_y), .box_width(box_width), .box_height(box_height),
		.alive(alive), .row_index(row_index),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .hit(hit), .partner_index(partner_index),
		.partner_id(partner_id), .partner_kind(partner_kind),
		.entry_total(entry_total), .last(last),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < rx_idle_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Mostly a crowded region so boxes overlap, sometimes anywhere.
	function automatic logic [15:0] rand_coord();
		if ($urandom_range(99) < 15)
			return 16'($urandom);
		return 16'(int'($urandom_range(600)) - 300);
	endfunction

	function automatic logic [7:0] rand_extent();
		case ($urandom_range(9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return $urandom_range(1) ? 8'($urandom_range(1, 60)) : 8'($urandom);
		endcase
	endfunction

	task automatic send_txn(input logic cmd, input logic [ID_W-1:0] id,
	                        input logic [KIND_W-1:0] kind, input logic [15:0] x,
	                        input logic [15:0] y, input logic [7:0] w,
	                        input logic [7:0] h, input logic alv,
	                        input logic [ROW_W-1:0] row);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		object_id <= id;
		object_kind <= kind;
		pos_x <= x;
		pos_y <= y;
		box_width <= w;
		box_height <= h;
		alive <= alv;
		row_index <= row;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	initial begin
		int               n;
		int               drop_pct;
		logic [KEY_W-1:0] pick;

		drop_pct = 10;
		for (n = 0; n < KEY_POOL; n++)
			key_pool[n] = KEY_W'($urandom);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_txn(CMD_QUERY, 16'h0000, 4'h0, 16'h0000, 16'h0000, 8'h00, 8'h00, 1'b0, 6'd0);
		send_txn(CMD_UPDATE, 16'h0000, 4'h0, 16'h0000, 16'h0000, 8'h08, 8'h08, 1'b0, 6'd0);
		send_txn(CMD_UPDATE, 16'h0000, 4'h0, 16'h8000, 16'h8000, 8'hFF, 8'hFF, 1'b1, 6'd0);
		// Right and bottom edges of this box lie beyond the 16-bit range.
		send_txn(CMD_UPDATE, 16'hFFFF, 4'hF, 16'h7FFF, 16'h7FFF, 8'hFF, 8'hFF, 1'b1, 6'h3F);
		// Its far corner lands exactly on the corner of the previous box.
		send_txn(CMD_UPDATE, 16'h0000, 4'hF, 16'h7F80, 16'h7F80, 8'h80, 8'h80, 1'b1, 6'd0);
		send_txn(CMD_UPDATE, 16'hFFFF, 4'h0, 16'h7FFF, 16'h7FFF, 8'h00, 8'h00, 1'b1, 6'd0);
		send_txn(CMD_QUERY, 16'h0000, 4'h0, 16'h0000, 16'h0000, 8'h00, 8'h00, 1'b0, 6'd0);
		send_txn(CMD_QUERY, 16'h0000, 4'h0, 16'h0000, 16'h0000, 8'h00, 8'h00, 1'b0, 6'd1);
		send_txn(CMD_QUERY, 16'h0000, 4'h0, 16'h0000, 16'h0000, 8'h00, 8'h00, 1'b0, 6'd2);
		send_txn(CMD_QUERY, 16'h0000, 4'h0, 16'h0000, 16'h0000, 8'h00, 8'h00, 1'b0, 6'd3);
		send_txn(CMD_QUERY, 16'h0000, 4'h0, 16'h0000, 16'h0000, 8'h00, 8'h00, 1'b0, 6'd4);
		send_txn(CMD_QUERY, 16'hFFFF, 4'hF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 1'b1, 6'h3F);
		// One unit short of the neighbor, then exactly touching it.
		send_txn(CMD_UPDATE, 16'h0000, 4'h0, 16'h7E81, 16'h7F80, 8'hFF, 8'h10, 1'b1, 6'd0);
		send_txn(CMD_QUERY, 16'h0000, 4'h0, 16'h0000, 16'h0000, 8'h00, 8'h00, 1'b0, 6'd0);
		send_txn(CMD_UPDATE, 16'h0000, 4'h0, 16'h7E82, 16'h7F80, 8'hFF, 8'h10, 1'b1, 6'd0);
		send_txn(CMD_QUERY, 16'h0000, 4'h0, 16'h0000, 16'h0000, 8'h00, 8'h00, 1'b0, 6'd0);
		send_txn(CMD_UPDATE, 16'hFFFF, 4'hF, 16'h0000, 16'h0000, 8'h00, 8'h00, 1'b0, 6'd0);
		send_txn(CMD_QUERY, 16'h0000, 4'h0, 16'h0000, 16'h0000, 8'h00, 8'h00, 1'b0, 6'd0);
		send_txn(CMD_UPDATE, 16'h0000, 4'h0, 16'h0000, 16'h0000, 8'h00, 8'h00, 1'b0, 6'd0);
		send_txn(CMD_UPDATE, 16'h0000, 4'h0, 16'h0000, 16'h0000, 8'h00, 8'h00, 1'b0, 6'd0);
		send_txn(CMD_QUERY, 16'h0000, 4'h0, 16'h0000, 16'h0000, 8'h00, 8'h00, 1'b0, 6'd0);

		for (n = 0; n < RANDOM_TXNS; n++) begin
			if (n == RANDOM_TXNS / 3) begin
				tx_idle_pct = 50;
				rx_idle_pct <= 36;
			end
			if (n == 2 * RANDOM_TXNS / 3) begin
				tx_idle_pct = 0;
				rx_idle_pct <= 0;
			end
			// Pick filling or draining stretches at random so the table both
			// overflows and empties.
			if (n % 50 == 0)
				drop_pct = $urandom_range(1) ? 8 : 55;
			pick = key_pool[$urandom_range(KEY_POOL - 1)];
			if ($urandom_range(99) < 20)
				send_txn(CMD_QUERY, 16'($urandom), 4'($urandom), 16'($urandom),
				         16'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
				         ($urandom_range(3) == 0) ? 6'($urandom_range(63))
				                                  : 6'($urandom_range(31)));
			else
				send_txn(CMD_UPDATE, pick[KEY_W-1:KIND_W], pick[KIND_W-1:0],
				         rand_coord(), rand_coord(), rand_extent(), rand_extent(),
				         $urandom_range(99) >= drop_pct, 6'($urandom));
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
